[rtl/tbd_pkg.sv]
// Shared types, constants and banner lookup for the torrent handshake detector.
`timescale 1ns / 1ps
package tbd_pkg;

    localparam int unsigned BANNER_LEN_DEF = 20;
    localparam int unsigned SKIP_LEN_DEF   = 48;
    localparam int unsigned TABLE_LEN      = 20;
    localparam int unsigned LEN_BYTES      = 4;

    typedef enum logic [1:0] {
        V_WAIT    = 2'd0,
        V_MATCH   = 2'd1,
        V_NOMATCH = 2'd2
    } t_verdict;

    // Per-request result from the core: emit says a result item is produced.
    typedef struct packed {
        logic     emit;
        t_verdict verdict;
    } t_step_res;

    localparam logic [7:0] BANNER_TABLE [TABLE_LEN] = '{
        8'd19, 8'h42, 8'h69, 8'h74, 8'h54, 8'h6f, 8'h72, 8'h72, 8'h65, 8'h6e,
        8'h74, 8'h20, 8'h70, 8'h72, 8'h6f, 8'h74, 8'h6f, 8'h63, 8'h6f, 8'h6c
    };

    // Positions past the known banner expect zero.
    function automatic logic [7:0] banner_at(input logic [31:0] i);
        logic [7:0] v;
        v = 8'd0;
        if (i < 32'(TABLE_LEN)) begin
            v = BANNER_TABLE[i[4:0]];
        end
        return v;
    endfunction

endpackage

[rtl/tbd_core.sv]
// Handshake parse state: banner compare, skip count, length gather, data count.
`timescale 1ns / 1ps
module tbd_core
    import tbd_pkg::*;
#(
    parameter int unsigned BANNER_LEN = BANNER_LEN_DEF,
    parameter int unsigned SKIP_LEN   = SKIP_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_in_segment,
    input  logic       i_from_responder,
    input  logic       i_flow_start,
    output t_step_res  o_res
);

    typedef enum logic [2:0] {
        PH_BANNER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [31:0] r_pos, n_pos, cur_pos, pos_inc;
    logic [31:0] r_len, n_len, cur_len;
    logic        decided;
    t_verdict    dec_verdict;

    always_comb begin
        // flow_start clears state before this byte is used
        cur_phase   = i_flow_start ? PH_BANNER : r_phase;
        cur_pos     = i_flow_start ? 32'd0 : r_pos;
        cur_len     = i_flow_start ? 32'd0 : r_len;
        pos_inc     = cur_pos + 32'd1;
        n_phase     = cur_phase;
        n_pos       = cur_pos;
        n_len       = cur_len;
        decided     = 1'b0;
        dec_verdict = V_WAIT;
        o_res.emit    = 1'b0;
        o_res.verdict = V_WAIT;

        if (cur_phase inside {PH_BANNER, PH_SKIP, PH_LENGTH, PH_DATA}) begin
            if (i_from_responder) begin
                case (cur_phase)
                    PH_BANNER: begin
                        if (i_data_byte != banner_at(cur_pos)) begin
                            decided     = 1'b1;
                            dec_verdict = V_NOMATCH;
                        end else if (cur_pos == 32'(BANNER_LEN - 1)) begin
                            n_phase = PH_SKIP;
                            n_pos   = 32'd0;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_SKIP: begin
                        if (cur_pos == 32'(SKIP_LEN - 1)) begin
                            n_phase = PH_LENGTH;
                            n_pos   = 32'd0;
                            n_len   = 32'd0;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_LENGTH: begin
                        n_len = {cur_len[23:0], i_data_byte};
                        n_pos = pos_inc;
                        if (pos_inc == 32'(LEN_BYTES)) begin
                            n_pos   = 32'd0;
                            n_phase = PH_DATA;
                            // zero length: match only at a segment end
                            if (n_len == 32'd0) begin
                                decided     = 1'b1;
                                dec_verdict = i_last_in_segment ? V_MATCH : V_NOMATCH;
                            end
                        end
                    end
                    default: begin
                        n_pos = pos_inc;
                        if (pos_inc == cur_len) begin
                            decided     = 1'b1;
                            dec_verdict = V_MATCH;
                        end
                    end
                endcase
            end

            if (decided) begin
                n_phase       = PH_DONE;
                o_res.emit    = 1'b1;
                o_res.verdict = dec_verdict;
            end else if (i_last_in_segment) begin
                o_res.emit    = 1'b1;
                o_res.verdict = V_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BANNER;
            r_pos   <= 32'd0;
            r_len   <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

endmodule

[rtl/torrent_handshake_detector.sv]
// A result appears on the output register in the cycle after its request is taken.
// Throughput: one request per cycle; the parse state updates in a single pass per byte.
// The input side stalls only while a held result is not taken by the sink.
// Reset (synchronous, active low) returns the parser to the banner phase with
// position and length at zero and empties the output register.
// Top level of the torrent handshake detector.
`timescale 1ns / 1ps
module torrent_handshake_detector
    import tbd_pkg::*;
#(
    parameter int unsigned BANNER_LEN = BANNER_LEN_DEF,
    parameter int unsigned SKIP_LEN   = SKIP_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_in_segment,
    input  logic       i_from_responder,
    input  logic       i_flow_start,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_verdict
);

    logic      accept;
    t_step_res step_res;
    logic      r_out_valid;
    t_verdict  r_verdict;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    tbd_core #(
        .BANNER_LEN (BANNER_LEN),
        .SKIP_LEN   (SKIP_LEN)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (i_data_byte),
        .i_last_in_segment (i_last_in_segment),
        .i_from_responder  (i_from_responder),
        .i_flow_start      (i_flow_start),
        .o_res             (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= accept && step_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && accept && step_res.emit) begin
            r_verdict <= step_res.verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

[rtl/tbd_checker.sv]
// Port-level assertions for the torrent handshake detector, with bind.
`timescale 1ns / 1ps
module tbd_checker
    import tbd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_last_in_segment,
    input logic       i_from_responder,
    input logic       i_flow_start,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_verdict
);

    // held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict))
        else $error("output result changed while stalled");

    // an empty output register never blocks the input side
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == V_WAIT || o_verdict == V_MATCH
                         || o_verdict == V_NOMATCH))
        else $error("illegal verdict code");

    // fresh flow, initiator byte ending a segment: in-progress result next
    a_fresh_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_flow_start && i_last_in_segment && !i_from_responder
        |=> o_out_valid && o_verdict == V_WAIT)
        else $error("missing in-progress result on new flow");

endmodule

bind torrent_handshake_detector tbd_checker u_tbd_checker (.*);
